[hw/rtl/i2dt_pkg.sv]
// Shared constants and types for the signed 64-bit to decimal text converter.
package i2dt_pkg;

  // Widths of the input value and the output character.
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned CHAR_W  = 6;

  // A 64-bit magnitude needs at most 20 decimal digits of 4 bits each.
  localparam int unsigned DIGITS  = 20;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned BCD_W   = DIGITS * DIGIT_W;

  // Width of the bit counter of the conversion and of the digit counter.
  localparam int unsigned BIT_CNT_W = $clog2(VALUE_W);
  localparam int unsigned REM_W     = $clog2(DIGITS + 1);

  // ASCII codes, already cut to the character width.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

  // Finished conversion handed from the converter to the character emitter.
  typedef struct packed {
    logic             neg;
    logic [BCD_W-1:0] bcd;
  } conv_result_t;

endpackage

[hw/rtl/i2dt_bcd_conv.sv]
// Bit-serial binary to BCD converter (shift and add 3), one input bit per cycle.
module i2dt_bcd_conv (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [i2dt_pkg::VALUE_W-1:0] value_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output i2dt_pkg::conv_result_t         res_o
);
  import i2dt_pkg::*;

  typedef enum logic [1:0] {
    C_IDLE,
    C_SHIFT,
    C_DONE
  } conv_state_e;

  conv_state_e          state_q;
  logic [BIT_CNT_W-1:0] cnt_q;
  logic [VALUE_W-1:0]   mag_q, mag_d;
  logic [BCD_W-1:0]     bcd_q, bcd_d;
  logic                 neg_q;
  logic [VALUE_W-1:0]   raw;
  logic [BCD_W-1:0]     adj;

  assign raw = value_i;

  // Add three to every digit of five or more, then shift in the next magnitude bit.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_q[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
      end
    end
    bcd_d = {adj[BCD_W-2:0], mag_q[VALUE_W-1]};
    mag_d = {mag_q[VALUE_W-2:0], 1'b0};
  end

  // Sequencer: take a value, run one pass per input bit, then hold the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        C_IDLE: begin
          if (in_valid_i) begin
            state_q <= C_SHIFT;
            cnt_q   <= '0;
          end
        end
        C_SHIFT: begin
          cnt_q <= cnt_q + BIT_CNT_W'(1);
          if (cnt_q == BIT_CNT_W'(VALUE_W - 1)) begin
            state_q <= C_DONE;
          end
        end
        C_DONE: begin
          if (res_ready_i) begin
            state_q <= C_IDLE;
          end
        end
        default: begin
          state_q <= C_IDLE;
        end
      endcase
    end
  end

  // Data path: load the magnitude on a transfer, shift while converting.
  always_ff @(posedge clk_i) begin
    if (state_q == C_IDLE && in_valid_i) begin
      neg_q <= raw[VALUE_W-1];
      mag_q <= raw[VALUE_W-1] ? VALUE_W'(~raw + VALUE_W'(1)) : raw;
      bcd_q <= '0;
    end else if (state_q == C_SHIFT) begin
      mag_q <= mag_d;
      bcd_q <= bcd_d;
    end
  end

  assign in_ready_o  = (state_q == C_IDLE);
  assign res_valid_o = (state_q == C_DONE);
  assign res_o.neg   = neg_q;
  assign res_o.bcd   = bcd_q;

endmodule

[hw/rtl/i2dt_char_emit.sv]
// Character emitter: sign, leading-zero skip and one ASCII digit per transfer.
module i2dt_char_emit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          res_valid_i,
  output logic                          res_ready_o,
  input  i2dt_pkg::conv_result_t        res_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [i2dt_pkg::CHAR_W-1:0]   text_char_o,
  output logic                          last_char_o
);
  import i2dt_pkg::*;

  typedef enum logic [1:0] {
    E_IDLE,
    E_SIGN,
    E_SKIP,
    E_DIGIT
  } emit_state_e;

  emit_state_e         state_q;
  logic [BCD_W-1:0]    digits_q;
  logic [REM_W-1:0]    rem_q;
  logic                out_valid_q;
  logic [CHAR_W-1:0]   char_q;
  logic                last_q;
  logic                out_free;
  logic                out_load;
  logic [DIGIT_W-1:0]  top;

  // The output register can take a new character when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;
  assign top      = digits_q[BCD_W-1 -: DIGIT_W];

  // A character is loaded by the sign step or by a digit step.
  assign out_load = out_free && (state_q == E_SIGN || state_q == E_DIGIT);

  // Sequencer and output register; the digit store shifts one digit per step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= E_IDLE;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        E_IDLE: begin
          if (res_valid_i) begin
            rem_q   <= REM_W'(DIGITS);
            state_q <= res_i.neg ? E_SIGN : E_SKIP;
          end
        end
        E_SIGN: begin
          if (out_free) begin
            state_q <= E_SKIP;
          end
        end
        E_SKIP: begin
          if (top == '0 && rem_q > REM_W'(1)) begin
            rem_q <= rem_q - REM_W'(1);
          end else begin
            state_q <= E_DIGIT;
          end
        end
        E_DIGIT: begin
          if (out_free) begin
            rem_q <= rem_q - REM_W'(1);
            if (rem_q == REM_W'(1)) begin
              state_q <= E_IDLE;
            end
          end
        end
        default: begin
          state_q <= E_IDLE;
        end
      endcase
    end
  end

  // Payload: digit store and the character being offered.
  always_ff @(posedge clk_i) begin
    case (state_q)
      E_IDLE: begin
        if (res_valid_i) begin
          digits_q <= res_i.bcd;
        end
      end
      E_SIGN: begin
        if (out_free) begin
          char_q <= CHAR_MINUS;
          last_q <= 1'b0;
        end
      end
      E_SKIP: begin
        if (top == '0 && rem_q > REM_W'(1)) begin
          digits_q <= {digits_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        end
      end
      E_DIGIT: begin
        if (out_free) begin
          char_q   <= CHAR_ZERO + CHAR_W'(top);
          last_q   <= (rem_q == REM_W'(1));
          digits_q <= {digits_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        end
      end
      default: begin
        digits_q <= digits_q;
      end
    endcase
  end

  assign res_ready_o = (state_q == E_IDLE);
  assign out_valid_o = out_valid_q;
  assign text_char_o = char_q;
  assign last_char_o = last_q;

endmodule

[hw/rtl/signed_int64_to_decimal_text.sv]
// Top level of the signed 64-bit integer to decimal ASCII text converter.
//
// Input channel: in_valid_i / in_ready_o carry one signed 64-bit value_i per
// transfer. Output channel: out_valid_o / out_ready_i carry one character per
// transfer, text_char_o being '-' or a digit, most significant first, with
// last_char_o high on the final character of a number (1 to 20 characters).
// A value is converted by a bit-serial shift-and-add-3 unit that consumes one
// magnitude bit per cycle. The emitter then skips leading zeros at one digit
// per cycle and offers one digit per cycle while the receiver takes them.
// Emission of one number overlaps the conversion of the next, so a new value
// can be taken while the previous number is still being emitted. A stalled
// receiver holds the current character in the output register; the converter
// then waits with its finished result and stops taking new values. Reset
// empties both stages; no state is kept between numbers.
module signed_int64_to_decimal_text (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [i2dt_pkg::VALUE_W-1:0] value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [i2dt_pkg::CHAR_W-1:0]        text_char_o,
  output logic                               last_char_o
);
  import i2dt_pkg::*;

  conv_result_t res;
  logic         res_valid;
  logic         res_ready;

  // Binary to BCD conversion, one bit per cycle.
  i2dt_bcd_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Sign and digit emission, one character per transfer.
  i2dt_char_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .text_char_o (text_char_o),
    .last_char_o (last_char_o)
  );

endmodule
